>>> sv/adcma_pkg.sv
`default_nettype none

package adcma_pkg;

    // Window length and the widths that follow from it.
    localparam int WINDOW_LEN = 16;
    localparam int SAMPLE_W   = 10;
    localparam int IDX_W      = $clog2(WINDOW_LEN);
    localparam int POS_W      = $clog2(WINDOW_LEN + 1);
    localparam int TOTAL_W    = $clog2((2 ** SAMPLE_W - 1) * WINDOW_LEN + 1);
    localparam int DIV_CNT_W  = $clog2(TOTAL_W + 1);

    // Configuration port and register widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;
    localparam int OFFSET_W   = 16;
    localparam int MULT_W     = 16;

    // Scaling arithmetic: (avg * 4 + offset) * multiplier.
    localparam int SUM_W      = OFFSET_W + 1;
    localparam int PROD_W     = SUM_W + MULT_W + 1;
    localparam int SCALED_W   = 33;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd3;

    // Multiplier reset value is 1.0 in Q8.8.
    localparam logic [MULT_W-1:0] MULT_RESET = 16'd256;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [TOTAL_W-1:0]  t_total;
    typedef logic [POS_W-1:0]    t_pos;

endpackage

`default_nettype wire

>>> sv/adcma_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module adcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/adcma_div.sv
`default_nettype none

// Restoring divider: one quotient bit per cycle over the width of the total.
module adcma_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire adcma_pkg::t_total        i_dividend,
    input  wire adcma_pkg::t_pos          i_divisor,
    output logic                          o_done,
    output adcma_pkg::t_sample            o_quot
);

    adcma_pkg::t_total                    r_dq;
    adcma_pkg::t_pos                      r_rem;
    adcma_pkg::t_pos                      r_div;
    logic [adcma_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic                                 r_busy;
    logic [adcma_pkg::POS_W:0]            trial;
    logic [adcma_pkg::POS_W:0]            trial_diff;
    logic                                 take;

    // Shift the next dividend bit into the partial remainder and compare.
    assign trial      = {r_rem, r_dq[adcma_pkg::TOTAL_W-1]};
    assign trial_diff = trial - {1'b0, r_div};
    assign take       = (trial >= {1'b0, r_div});

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= adcma_pkg::DIV_CNT_W'(adcma_pkg::TOTAL_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - adcma_pkg::DIV_CNT_W'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend, remainder and divisor datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_dq  <= {r_dq[adcma_pkg::TOTAL_W-2:0], take};
            r_rem <= take ? trial_diff[adcma_pkg::POS_W-1:0] : trial[adcma_pkg::POS_W-1:0];
        end
    end

    // The quotient never exceeds the largest sample value.
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_dq[adcma_pkg::SAMPLE_W-1:0];

endmodule

`default_nettype wire

>>> sv/adc_moving_average_with_warmup_top.sv
// Moving-average filter for a 10-bit converter with a warm-up phase.
// Input channel: i_in_valid / o_in_stall carry one sample per beat. Output
// channel: o_out_valid / i_out_stall carry one result beat per input beat,
// in order: valid_res, average, changed and scaled_value.
// Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
// (0 enable, 1 force_report, 2 offset, 3 multiplier); write only when idle.
// The window of past samples lives in a small RAM; each sample does a
// read-modify-write of one entry, then the total goes through a one-bit-per-
// cycle divider (TOTAL_W = 14 steps) and one 17x17 multiply.
// An enabled sample passes through the update, divide, multiply and completion
// states, and no new sample is taken until it has completed. A disabled
// sample goes straight to completion, with valid_res low and no state change.
// Reset clears the totals and the last reported values but not the window RAM
// (an entry reads as zero until the ring first wraps); it needs no clearing pass.
// When the receiver stalls, the finished result waits in the output register
// and the next sample is still taken and processed; it then waits for the
// output register to free up before it completes.
`default_nettype none

module adc_moving_average_with_warmup_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration port.
    input  wire logic                                   i_cfg_we,
    input  wire logic [adcma_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [adcma_pkg::CFG_W-1:0]            i_cfg_data,
    // Input channel.
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [adcma_pkg::SAMPLE_W-1:0]         i_sample,
    // Output channel.
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_valid_res,
    output logic [adcma_pkg::SAMPLE_W-1:0]              o_average,
    output logic                                        o_changed,
    output logic signed [adcma_pkg::SCALED_W-1:0]       o_scaled_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    // Configuration registers.
    logic                                 r_enable;
    logic                                 r_force;
    logic [adcma_pkg::OFFSET_W-1:0]       r_offset;
    logic [adcma_pkg::MULT_W-1:0]         r_mult;

    // Sequencer and filter state.
    logic [2:0]                           r_state;
    logic [2:0]                           n_state;
    logic                                 r_en;
    adcma_pkg::t_pos                      r_wpos;
    logic                                 r_full;
    adcma_pkg::t_total                    r_total;
    adcma_pkg::t_sample                   r_last_rep;
    logic signed [adcma_pkg::SCALED_W-1:0] r_last_scaled;

    // Per-beat working registers.
    adcma_pkg::t_sample                   r_sample;
    logic [adcma_pkg::IDX_W-1:0]          r_slot;
    adcma_pkg::t_sample                   r_avg;
    logic                                 r_report;
    logic signed [adcma_pkg::SCALED_W-1:0] r_prod;

    // Output register.
    logic                                 r_out_vld;
    logic                                 r_o_valid_res;
    adcma_pkg::t_sample                   r_o_average;
    logic                                 r_o_changed;
    logic signed [adcma_pkg::SCALED_W-1:0] r_o_scaled;

    // Combinational signals.
    logic                                 in_acc;
    logic                                 wrap;
    logic [adcma_pkg::IDX_W-1:0]          slot;
    logic [adcma_pkg::IDX_W-1:0]          ram_raddr;
    adcma_pkg::t_sample                   ram_rdata;
    adcma_pkg::t_sample                   old_sample;
    adcma_pkg::t_total                    n_total;
    adcma_pkg::t_pos                      divisor;
    logic                                 div_done;
    adcma_pkg::t_sample                   div_quot;
    logic signed [adcma_pkg::SUM_W-1:0]   sum;
    logic signed [adcma_pkg::MULT_W:0]    mult_s;
    logic signed [adcma_pkg::PROD_W-1:0]  prod;
    logic                                 out_free;
    logic                                 out_load;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_vld || !i_out_stall;
    assign out_load = (r_state == ST_FIN) && out_free;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_force  <= 1'b0;
            r_offset <= '0;
            r_mult   <= adcma_pkg::MULT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                adcma_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                adcma_pkg::CFG_FORCE:  r_force  <= i_cfg_data[0];
                adcma_pkg::CFG_OFFSET: r_offset <= i_cfg_data[adcma_pkg::OFFSET_W-1:0];
                adcma_pkg::CFG_MULT:   r_mult   <= i_cfg_data[adcma_pkg::MULT_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring slot: wrap to zero once every slot of the current pass is used.
    assign wrap      = (r_wpos == adcma_pkg::POS_W'(adcma_pkg::WINDOW_LEN));
    assign slot      = wrap ? '0 : r_wpos[adcma_pkg::IDX_W-1:0];
    assign ram_raddr = slot;

    // Until the ring first wraps, the slot being replaced was never written.
    assign old_sample = r_full ? ram_rdata : '0;
    assign n_total    = r_total - adcma_pkg::TOTAL_W'(old_sample)
                                + adcma_pkg::TOTAL_W'(r_sample);
    assign divisor    = r_full ? adcma_pkg::POS_W'(adcma_pkg::WINDOW_LEN) : r_wpos;

    adcma_ram #(
        .WIDTH (adcma_pkg::SAMPLE_W),
        .DEPTH (adcma_pkg::WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPD),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    adcma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_UPD),
        .i_dividend (n_total),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Scaled value: average in Q.12 plus signed offset, times Q8.8 multiplier.
    assign sum    = $signed({{(adcma_pkg::SUM_W - adcma_pkg::SAMPLE_W - 2){1'b0}},
                             div_quot, 2'b00})
                  + $signed({{(adcma_pkg::SUM_W - adcma_pkg::OFFSET_W){r_offset[adcma_pkg::OFFSET_W-1]}},
                             r_offset});
    assign mult_s = $signed({1'b0, r_mult});
    assign prod   = sum * mult_s;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_enable ? ST_UPD : ST_FIN;
                end
            end
            ST_UPD: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Control and filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wpos        <= '0;
            r_full        <= 1'b0;
            r_total       <= '0;
            r_last_rep    <= '0;
            r_last_scaled <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the ring position on an enabled sample.
            if (in_acc && r_enable) begin
                r_wpos <= {{(adcma_pkg::POS_W - adcma_pkg::IDX_W){1'b0}}, slot}
                          + adcma_pkg::POS_W'(1);
                if (wrap) begin
                    r_full <= 1'b1;
                end
            end
            if (r_state == ST_UPD) begin
                r_total <= n_total;
            end
            // Commit a report.
            if (out_load && r_en && r_report) begin
                r_last_rep    <= r_avg;
                r_last_scaled <= r_prod;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Per-beat working registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_en     <= r_enable;
            r_sample <= i_sample;
            r_slot   <= slot;
        end
        if (r_state == ST_MUL) begin
            r_avg    <= div_quot;
            r_report <= (div_quot != r_last_rep) || r_force;
            r_prod   <= prod[adcma_pkg::SCALED_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_valid_res <= r_en;
            r_o_average   <= r_en ? r_avg : '0;
            r_o_changed   <= r_en && r_report;
            r_o_scaled    <= !r_en ? '0 : (r_report ? r_prod : r_last_scaled);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_valid_res    = r_o_valid_res;
    assign o_average      = r_o_average;
    assign o_changed      = r_o_changed;
    assign o_scaled_value = r_o_scaled;

    // A disabled sample goes straight to completion.
    a_disabled_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_enable) |=> (r_state == ST_FIN))
        else $error("disabled sample did not go straight to completion");

    // The ring position never runs past the window length.
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= adcma_pkg::POS_W'(adcma_pkg::WINDOW_LEN))
        else $error("ring position out of range");

    // The running total stays within the sum of a full window.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= adcma_pkg::TOTAL_W'((2 ** adcma_pkg::SAMPLE_W - 1) * adcma_pkg::WINDOW_LEN))
        else $error("running total out of range");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // A finished beat waits while the output register is held by the receiver.
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && r_out_vld && i_out_stall) |=> (r_state == ST_FIN))
        else $error("result overwrote a stalled output beat");

endmodule

`default_nettype wire

>>> dv/tb_adc_moving_average_with_warmup_top.sv
module tb_adc_moving_average_with_warmup_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 800000;

    // One result beat as seen on the output channel.
    typedef struct packed {
        logic                           valid_res;
        logic [adcma_pkg::SAMPLE_W-1:0] average;
        logic                           changed;
        logic [adcma_pkg::SCALED_W-1:0] scaled_value;
    } t_avg_beat;

    // Tracks the filter state, predicts each result beat and checks it in order.
    class avg_filter_scoreboard;
        bit                             en;
        bit                             force_rpt;
        logic [adcma_pkg::OFFSET_W-1:0] offset_q;
        logic [adcma_pkg::MULT_W-1:0]   mult_q;

        adcma_pkg::t_sample             ring[adcma_pkg::WINDOW_LEN];
        int unsigned                    fill_cnt;
        bit                             wrapped;
        int unsigned                    total;
        adcma_pkg::t_sample             last_avg;
        logic [adcma_pkg::SCALED_W-1:0] last_scaled;

        t_avg_beat           pending_averages[$];
        int                  errors;
        int                  beats_checked;
        int                  enabled_samples;
        int                  disabled_samples;
        int                  reports;
        int                  unchanged;

        function new();
            en          = 1'b0;
            force_rpt   = 1'b0;
            offset_q    = '0;
            mult_q      = adcma_pkg::MULT_RESET;
            foreach (ring[k]) ring[k] = '0;
            fill_cnt    = 0;
            wrapped     = 1'b0;
            total       = 0;
            last_avg    = '0;
            last_scaled = '0;
            errors           = 0;
            beats_checked    = 0;
            enabled_samples  = 0;
            disabled_samples = 0;
            reports          = 0;
            unchanged        = 0;
        endfunction

        function void set_reg(input logic [adcma_pkg::CFG_IDX_W-1:0] idx,
                              input logic [adcma_pkg::CFG_W-1:0] val);
            case (idx)
                adcma_pkg::CFG_ENABLE: en        = val[0];
                adcma_pkg::CFG_FORCE:  force_rpt = val[0];
                adcma_pkg::CFG_OFFSET: offset_q  = val[adcma_pkg::OFFSET_W-1:0];
                adcma_pkg::CFG_MULT:   mult_q    = val[adcma_pkg::MULT_W-1:0];
                default: ;
            endcase
        endfunction

        // An accepted sample updates the window and queues the beat it must produce.
        function void note_sample(input adcma_pkg::t_sample s);
            t_avg_beat   want;
            int unsigned divisor;
            longint      scaled;
            want = '0;
            if (!en) begin
                disabled_samples++;
            end else begin
                enabled_samples++;
                if (fill_cnt >= adcma_pkg::WINDOW_LEN) begin
                    fill_cnt = 0;
                    wrapped  = 1'b1;
                end
                total = total - ring[fill_cnt] + s;
                ring[fill_cnt] = s;
                fill_cnt++;
                divisor = wrapped ? adcma_pkg::WINDOW_LEN : fill_cnt;
                want.valid_res = 1'b1;
                want.average   = adcma_pkg::t_sample'(total / divisor);
                want.changed   = (want.average != last_avg) || force_rpt;
                if (want.changed) begin
                    // average/1024 in Q.12 plus the Q4.12 offset, times the Q8.8 scale.
                    scaled = (longint'(want.average) * 4 + longint'($signed(offset_q)))
                             * longint'(mult_q);
                    last_avg    = want.average;
                    last_scaled = scaled[adcma_pkg::SCALED_W-1:0];
                    reports++;
                end else begin
                    unchanged++;
                end
                want.scaled_value = last_scaled;
            end
            pending_averages.push_back(want);
        endfunction

        // Compares a result beat field by field with the oldest prediction.
        function void check_beat(input t_avg_beat got);
            t_avg_beat want;
            if (pending_averages.size() == 0) begin
                $error("result beat with no sample outstanding: average %0d", got.average);
                errors++;
            end else begin
                want = pending_averages.pop_front();
                beats_checked++;
                if (got.valid_res !== want.valid_res) begin
                    $error("valid_res mismatch: expected %0d, actual %0d",
                           want.valid_res, got.valid_res);
                    errors++;
                end
                if (got.average !== want.average) begin
                    $error("average mismatch: expected %0d, actual %0d",
                           want.average, got.average);
                    errors++;
                end
                if (got.changed !== want.changed) begin
                    $error("changed mismatch: expected %0d, actual %0d",
                           want.changed, got.changed);
                    errors++;
                end
                if (got.scaled_value !== want.scaled_value) begin
                    $error("scaled_value mismatch: expected %0d, actual %0d",
                           $signed(want.scaled_value), $signed(got.scaled_value));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction
    endclass

    logic                                  i_clk      = 1'b0;
    logic                                  i_rst_n    = 1'b0;
    logic                                  i_cfg_we   = 1'b0;
    logic [adcma_pkg::CFG_IDX_W-1:0]       i_cfg_idx  = '0;
    logic [adcma_pkg::CFG_W-1:0]           i_cfg_data = '0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic [adcma_pkg::SAMPLE_W-1:0]        i_sample   = '0;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic                                  o_valid_res;
    logic [adcma_pkg::SAMPLE_W-1:0]        o_average;
    logic                                  o_changed;
    logic signed [adcma_pkg::SCALED_W-1:0] o_scaled_value;

    avg_filter_scoreboard sb;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit hold_req    = 1'b0;
    int cycle_count = 0;
    int phase_count = 0;

    adc_moving_average_with_warmup_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_valid_res    (o_valid_res),
        .o_average      (o_average),
        .o_changed      (o_changed),
        .o_scaled_value (o_scaled_value)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watch both channels at the rising edge and feed the scoreboard.
    always @(posedge i_clk) begin
        t_avg_beat got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_sample(i_sample);
            if (o_out_valid && !i_out_stall) begin
                got.valid_res    = o_valid_res;
                got.average      = o_average;
                got.changed      = o_changed;
                got.scaled_value = o_scaled_value;
                sb.check_beat(got);
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("adc_moving_average_with_warmup_top test failed");
        $finish;
    end

    // Result side: random stall before each beat, plus one long hold on request.
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Offer one sample after a random gap and hold it until the block takes it.
    // Valid stays high afterwards so back-to-back beats need no extra edge.
    task automatic send_sample(input adcma_pkg::t_sample s);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic sender_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Wait for every predicted beat, then let the block settle.
    task automatic drain_results();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [adcma_pkg::CFG_IDX_W-1:0] idx,
                             input logic [adcma_pkg::CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Single-bit registers get random upper bits to show they are ignored.
    task automatic write_flag(input logic [adcma_pkg::CFG_IDX_W-1:0] idx, input bit val);
        logic [adcma_pkg::CFG_W-1:0] data;
        data    = adcma_pkg::CFG_W'($urandom());
        data[0] = val;
        write_reg(idx, data);
    endtask

    initial begin : stimulus
        adcma_pkg::t_sample          warmup_seq[$];
        adcma_pkg::t_sample          level;
        adcma_pkg::t_sample          s;
        int                          n;
        int                          style;
        int                          run_left;
        int                          tmp;
        bit                          en_v;
        logic [adcma_pkg::CFG_W-1:0] off_v;
        logic [adcma_pkg::CFG_W-1:0] mult_v;

        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: samples while disabled after reset.
        send_sample(10'd1023);
        send_sample(10'h2AA);
        sender_idle();
        drain_results();

        // Directed: warm-up through the first ring wrap, starting with an
        // average of zero that matches the reset value.
        write_flag(adcma_pkg::CFG_ENABLE, 1'b1);
        warmup_seq = {10'd0, 10'd0, 10'd1023, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd512,
                      10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                      10'd1023, 10'd1023, 10'd1023, 10'd0};
        foreach (warmup_seq[k]) send_sample(warmup_seq[k]);
        sender_idle();
        drain_results();

        // Directed: forced reports with extreme offset and scale.
        write_flag(adcma_pkg::CFG_FORCE, 1'b1);
        write_reg(adcma_pkg::CFG_OFFSET, 16'h8000);
        write_reg(adcma_pkg::CFG_MULT, 16'hFFFF);
        send_sample(10'd1023);
        send_sample(10'd1023);
        sender_idle();
        drain_results();
        write_flag(adcma_pkg::CFG_FORCE, 1'b0);
        write_reg(adcma_pkg::CFG_OFFSET, 16'h7FFF);
        send_sample(10'd1023);
        sender_idle();
        drain_results();
        write_reg(adcma_pkg::CFG_MULT, 16'h0000);
        send_sample(10'd0);
        sender_idle();

        // Random phases, each with its own register setting and sample shape.
        level    = '0;
        run_left = 0;
        while (sb.enabled_samples < ITEM_TARGET) begin
            drain_results();
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet = ($urandom_range(0, 4) == 0);
            if (phase_count == 0) begin
                // Lowest scaled value: all-zero window, most negative offset, top scale.
                write_flag(adcma_pkg::CFG_ENABLE, 1'b1);
                write_flag(adcma_pkg::CFG_FORCE, 1'b1);
                write_reg(adcma_pkg::CFG_OFFSET, 16'h8000);
                write_reg(adcma_pkg::CFG_MULT, 16'hFFFF);
                en_v = 1'b1; style = 1; level = '0; run_left = 1000; n = 24;
            end else if (phase_count == 1) begin
                // Highest scaled value: full-scale window, top offset and scale.
                write_flag(adcma_pkg::CFG_FORCE, 1'b0);
                write_reg(adcma_pkg::CFG_OFFSET, 16'h7FFF);
                write_reg(adcma_pkg::CFG_MULT, 16'hFFFF);
                en_v = 1'b1; style = 1; level = 10'd1023; run_left = 1000; n = 24;
            end else begin
                en_v = ($urandom_range(0, 7) != 0) || phase_count == 3 || phase_count == 5;
                write_flag(adcma_pkg::CFG_ENABLE, en_v);
                if ($urandom_range(0, 3) != 0) begin
                    write_flag(adcma_pkg::CFG_FORCE, $urandom_range(0, 2) == 0);
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 4))
                        0:       off_v = 16'h8000;
                        1:       off_v = 16'h7FFF;
                        2:       off_v = 16'h0000;
                        3:       off_v = 16'hFFFF;
                        default: off_v = adcma_pkg::CFG_W'($urandom());
                    endcase
                    write_reg(adcma_pkg::CFG_OFFSET, off_v);
                end
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 4))
                        0:       mult_v = 16'h0000;
                        1:       mult_v = 16'hFFFF;
                        2:       mult_v = adcma_pkg::MULT_RESET;
                        3:       mult_v = 16'h0001;
                        default: mult_v = adcma_pkg::CFG_W'($urandom());
                    endcase
                    write_reg(adcma_pkg::CFG_MULT, mult_v);
                end
                style    = $urandom_range(0, 3);
                run_left = 0;
                n        = en_v ? $urandom_range(20, 80) : $urandom_range(4, 12);
            end

            // Block the result side for a long stretch while samples keep coming.
            if (phase_count == 3) begin
                tx_quiet = 1'b1;
                hold_req = 1'b1;
                n        = 40;
            end

            for (int i = 0; i < n; i++) begin
                // Once, stop mid-phase until every outstanding beat has arrived.
                if (phase_count == 5 && i == n / 2) begin
                    sender_idle();
                    drain_results();
                end
                case (style)
                    0: s = adcma_pkg::t_sample'($urandom_range(0, 1023));
                    1: begin
                        if (run_left == 0) begin
                            level    = adcma_pkg::t_sample'($urandom_range(0, 1023));
                            run_left = $urandom_range(1, 40);
                        end
                        run_left--;
                        s = level;
                    end
                    2: begin
                        if ($urandom_range(0, 1) == 0) s = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                        else s = adcma_pkg::t_sample'($urandom_range(0, 1023));
                    end
                    default: begin
                        // Small noise around a slowly moving level.
                        if ($urandom_range(0, 15) == 0) begin
                            level = adcma_pkg::t_sample'($urandom_range(0, 1023));
                        end
                        tmp = int'(level) + int'($urandom_range(0, 6)) - 3;
                        if (tmp < 0) tmp = 0;
                        if (tmp > 1023) tmp = 1023;
                        s = adcma_pkg::t_sample'(tmp);
                    end
                endcase
                send_sample(s);
            end
            sender_idle();
            phase_count++;
        end

        drain_results();
        $display("Run covered %0d enabled and %0d disabled samples, %0d result beats checked.",
                 sb.enabled_samples, sb.disabled_samples, sb.beats_checked);
        $display("Averages: %0d reported, %0d unchanged; %0d register phases in %0d cycles.",
                 sb.reports, sb.unchanged, phase_count, cycle_count);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("adc_moving_average_with_warmup_top test passed");
        end else begin
            $display("adc_moving_average_with_warmup_top test failed");
        end
        $finish;
    end

endmodule
